// ===== rtl/ovp_pkg.sv =====
package ovp_pkg;

   localparam int TIME_BITS_DEFAULT = 32;
   localparam int CSR_INDEX_BITS = 8;

   typedef enum logic [1:0] {
      ST_INIT    = 2'd0,
      ST_NORMAL  = 2'd1,
      ST_WARNING = 2'd2,
      ST_FAULT   = 2'd3
   } state_type;

   typedef enum logic [1:0] {
      FLT_NONE      = 2'd0,
      FLT_SENSOR    = 2'd1,
      FLT_OVERPOWER = 2'd2,
      FLT_UNUSED    = 2'd3
   } fault_type;

   localparam logic [1:0] KIND_MEAS  = 2'd0;
   localparam logic [1:0] KIND_RESET = 2'd1;
   localparam logic [1:0] KIND_ACK   = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] REG_WARN_THR  = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FAULT_THR = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CONFIRM   = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MIN_VOLT  = 8'd3;

   localparam logic signed [31:0] WARN_THR_RESET  = 32'sd1800000;
   localparam logic signed [31:0] FAULT_THR_RESET = 32'sd2200000;
   localparam logic [31:0]        CONFIRM_RESET   = 32'd2000;
   localparam logic [19:0]        MIN_VOLT_RESET  = 20'd10000;

   typedef struct packed {
      logic signed [31:0] warning_threshold_mw;
      logic signed [31:0] fault_threshold_mw;
      logic [31:0]        confirm_time_ms;
      logic [19:0]        min_voltage_mv;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic               sample_valid;
      logic [19:0]        voltage_mv;
      logic signed [31:0] power_mw;
      logic [31:0]        time_ms;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  machine_state;
      logic [1:0]  fault_code;
      logic [1:0]  last_fault_code;
      logic        state_changed;
      logic        fault_changed;
      logic        command_ok;
      logic        acknowledged;
      logic [31:0] fault_count;
      logic        timer_running;
      logic [31:0] timer_age_ms;
      logic [31:0] fault_since_ms;
      logic [31:0] last_fault_time_ms;
   } rsp_payload_type;

endpackage

// ===== rtl/ovp_csr.sv =====
module ovp_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ovp_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [31:0]                         csr_wdata,
   output ovp_pkg::cfg_type                    cfg
);
   import ovp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_WARN_THR:  cfg_in.warning_threshold_mw = csr_wdata;
            REG_FAULT_THR: cfg_in.fault_threshold_mw = csr_wdata;
            REG_CONFIRM:   cfg_in.confirm_time_ms = csr_wdata;
            REG_MIN_VOLT:  cfg_in.min_voltage_mv = csr_wdata[19:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.warning_threshold_mw <= WARN_THR_RESET;
         cfg_ff.fault_threshold_mw <= FAULT_THR_RESET;
         cfg_ff.confirm_time_ms <= CONFIRM_RESET;
         cfg_ff.min_voltage_mv <= MIN_VOLT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/ovp_core.sv =====
module ovp_core #(
   parameter int TIME_BITS = ovp_pkg::TIME_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  ovp_pkg::req_payload_type item,
   input  ovp_pkg::cfg_type         cfg,
   output ovp_pkg::rsp_payload_type result
);
   import ovp_pkg::*;

   state_type            state_ff, state_in;
   fault_type            fault_ff, fault_in;
   fault_type            recent_ff, recent_in;
   logic [TIME_BITS-1:0] since_ff, since_in;
   logic [TIME_BITS-1:0] recent_stamp_ff, recent_stamp_in;
   logic [31:0]          total_ff, total_in;
   logic                 ack_ff, ack_in;
   logic                 run_ff, run_in;
   logic [TIME_BITS-1:0] start_ff, start_in;

   logic [63:0]          time_wide;
   logic [TIME_BITS-1:0] now;
   logic [TIME_BITS-1:0] age;
   logic [TIME_BITS-1:0] out_age;
   logic [63:0]          age_wide;
   logic [63:0]          since_wide;
   logic [63:0]          recent_stamp_wide;
   logic                 ok, sc, fc;
   logic                 raise;
   fault_type            raise_code;

   assign time_wide = 64'(item.time_ms);
   assign now = time_wide[TIME_BITS-1:0];

   always_comb begin
      state_in = state_ff;
      fault_in = fault_ff;
      recent_in = recent_ff;
      since_in = since_ff;
      recent_stamp_in = recent_stamp_ff;
      total_in = total_ff;
      ack_in = ack_ff;
      run_in = run_ff;
      start_in = start_ff;
      ok = 1'b0;
      sc = 1'b0;
      fc = 1'b0;
      raise = 1'b0;
      raise_code = FLT_NONE;
      age = '0;
      case (item.kind)
         KIND_MEAS: begin
            ok = 1'b1;
            if (state_ff != ST_FAULT) begin
               if (!item.sample_valid) begin
                  run_in = 1'b0;
                  raise = 1'b1;
                  raise_code = FLT_SENSOR;
               end else if (item.voltage_mv <= cfg.min_voltage_mv) begin
                  run_in = 1'b0;
                  state_in = ST_INIT;
               end else if (item.power_mw > cfg.fault_threshold_mw) begin
                  if (!run_ff) begin
                     start_in = now;
                  end
                  age = now - start_in;
                  if (64'(age) >= 64'(cfg.confirm_time_ms)) begin
                     run_in = 1'b0;
                     raise = 1'b1;
                     raise_code = FLT_OVERPOWER;
                  end else begin
                     run_in = 1'b1;
                     state_in = ST_WARNING;
                  end
               end else if (item.power_mw > cfg.warning_threshold_mw) begin
                  run_in = 1'b0;
                  state_in = ST_WARNING;
               end else begin
                  run_in = 1'b0;
                  state_in = ST_NORMAL;
               end
               if (raise && !(fault_ff != FLT_NONE && fault_ff == raise_code)) begin
                  fault_in = raise_code;
                  recent_in = raise_code;
                  since_in = now;
                  recent_stamp_in = now;
                  total_in = total_ff + 32'd1;
                  ack_in = 1'b0;
                  state_in = ST_FAULT;
               end
               sc = state_in != state_ff;
               fc = fault_in != fault_ff;
            end
         end
         KIND_RESET: begin
            if (fault_ff != FLT_NONE) begin
               ok = 1'b1;
               fault_in = FLT_NONE;
               ack_in = 1'b0;
               since_in = '0;
               run_in = 1'b0;
               start_in = '0;
               state_in = ST_INIT;
            end
         end
         KIND_ACK: begin
            if (fault_ff != FLT_NONE) begin
               ok = 1'b1;
               ack_in = 1'b1;
            end
         end
         default: ok = 1'b0;
      endcase
   end

   assign out_age = run_in ? (now - start_in) : '0;
   assign age_wide = 64'(out_age);
   assign since_wide = 64'(since_in);
   assign recent_stamp_wide = 64'(recent_stamp_in);

   always_comb begin
      result.machine_state = state_in;
      result.fault_code = fault_in;
      result.last_fault_code = recent_in;
      result.state_changed = sc;
      result.fault_changed = fc;
      result.command_ok = ok;
      result.acknowledged = ack_in;
      result.fault_count = total_in;
      result.timer_running = run_in;
      result.timer_age_ms = age_wide[31:0];
      result.fault_since_ms = since_wide[31:0];
      result.last_fault_time_ms = recent_stamp_wide[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         fault_ff <= FLT_NONE;
         recent_ff <= FLT_NONE;
         since_ff <= '0;
         recent_stamp_ff <= '0;
         total_ff <= '0;
         ack_ff <= 1'b0;
         run_ff <= 1'b0;
         start_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
         fault_ff <= fault_in;
         recent_ff <= recent_in;
         since_ff <= since_in;
         recent_stamp_ff <= recent_stamp_in;
         total_ff <= total_in;
         ack_ff <= ack_in;
         run_ff <= run_in;
         start_ff <= start_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_fault_matches_state: assert property (@(posedge clock) disable iff (reset)
      (fault_ff != FLT_NONE) == (state_ff == ST_FAULT))
      else $error("active fault and fault state disagree");

   a_no_timer_in_fault: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FAULT |-> !run_ff)
      else $error("confirmation timer running while latched");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      advance && (fault_in != fault_ff) && (fault_in != FLT_NONE)
      |=> total_ff == $past(total_ff) + 32'd1)
      else $error("fault count did not advance on a new fault");
`endif

endmodule

// ===== rtl/overpower_protection_trip_top.sv =====
// Overpower protection trip relay.
// req_ channel: one item per handshake, either a timestamped measurement
// (kind 0) or a fault reset (kind 1) / acknowledge (kind 2) command.
// rsp_ channel: exactly one result item per request item, in order, giving
// the machine state, fault codes, counters, timer and stamps after it.
// csr_ channel: writes thresholds, confirm time and minimum voltage by index;
// it is always ready; the user must write it only while no item is in flight,
// which the block itself does not enforce. A result passes from the input
// register through the decision logic into the result register.
// Throughput: one item per cycle unless rsp_ready stalls; the state update is
// a single compare and subtract pass between the input and result registers.
// When rsp_ready is low the result register holds, the input register keeps
// one more item, and req_ready drops only when both are full.
// Reset (synchronous, active high) empties both registers, restores the
// register defaults and returns the machine to init with all counters and
// stamps at zero.
module overpower_protection_trip_top #(
   parameter int TIME_BITS = ovp_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  ovp_pkg::req_payload_type            req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output ovp_pkg::rsp_payload_type            rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ovp_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [31:0]                         csr_wdata
);
   import ovp_pkg::*;

   cfg_type         cfg;
   logic            in_valid_ff, in_valid_in;
   req_payload_type in_data_ff;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_data_ff;
   rsp_payload_type result;
   logic            advance;

   ovp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ovp_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_data_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign advance = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_payload = out_data_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_payload;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

`ifndef NO_ASSERTIONS
   a_advance_fills_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("result register not loaded after an item moved");

   a_idle_timer_age: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.timer_running |-> rsp_payload.timer_age_ms == 32'd0)
      else $error("timer age nonzero while timer stopped");

   a_change_only_meas: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.state_changed || rsp_payload.fault_changed)
      |-> rsp_payload.command_ok)
      else $error("change flags set on an ineffective item");
`endif

endmodule
